### rtl/core/fixed_point_atan2_degrees_defines.svh
// Assertion macros used by the fixed-point atan2 top level.
`ifndef FIXED_POINT_ATAN2_DEGREES_DEFINES_SVH
`define FIXED_POINT_ATAN2_DEGREES_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge out of reset.
`define FPA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge out of reset.
`define FPA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fpa_pkg.sv
// Shared constants and types for the fixed-point atan2 block.
`default_nettype none

package fpa_pkg;

  // Default number of fraction bits in the ratio
  localparam int FRAC_BITS_DEF = 10;

  // Field widths
  localparam int IN_W  = 16;        // y / x components
  localparam int MAG_W = IN_W + 1;  // |y| and divisor magnitude (up to 65536)
  localparam int ANG_W = 9;         // angle in degrees

  // Polynomial sum needs this many bits above the fraction bits
  localparam int POLY_GROW = 8;

  // Angle constants
  localparam int BASE_RIGHT = 45;
  localparam int BASE_LEFT  = 135;
  localparam int LIN_COEF   = -56;
  localparam int CUBE_COEF  = 11;
  localparam int HALF_TURN  = 180;

  // Side information that rides along with each request
  typedef struct packed {
    logic y_zero;  // y is zero: fixed answer, ratio unused
    logic x_neg;   // left half plane: base 135
    logic y_neg;   // negate the final angle
    logic neg_q;   // ratio numerator negative
  } side_t;

endpackage

`default_nettype wire

### rtl/core/fpa_if.sv
// Valid/ready channel interfaces for the atan2 request and result streams.
`default_nettype none

interface fpa_in_if import fpa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  y_value;
  logic signed [IN_W-1:0]  x_value;

  modport source (output valid, output y_value, output x_value, input ready);
  modport sink   (input valid, input y_value, input x_value, output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ANG_W-1:0]  angle_deg;

  modport source (output valid, output angle_deg, input ready);
  modport sink   (input valid, input angle_deg, output ready);
endinterface

`default_nettype wire

### rtl/core/fpa_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage.
`default_nettype none

module fpa_div import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_W-1:0]      num_mag,
  input  logic [MAG_W-1:0]     den,
  input  side_t                in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   quo,
  output side_t                out_side
);

  // Numerator never exceeds the divisor, so the quotient has FRAC_BITS+1 bits
  localparam int NST = FRAC_BITS + 1;

  logic [NST-1:0]     vld_r;
  logic [NST:0]       rdy;
  logic [MAG_W-1:0]   rem_r  [NST];
  logic [MAG_W-1:0]   den_r  [NST];
  logic [FRAC_BITS:0] quo_r  [NST];
  side_t              side_r [NST];

  assign rdy[NST] = out_ready;

  for (genvar i = 0; i < NST; i++) begin : g_stage
    logic [MAG_W:0]     trial;
    logic [MAG_W-1:0]   den_in;
    logic [FRAC_BITS:0] quo_in;
    side_t              side_in;
    logic               vld_in;
    logic               ge;

    // A stage moves when it is empty or its successor moves
    assign rdy[i] = !vld_r[i] || rdy[i+1];

    if (i == 0) begin : g_first
      assign trial   = {2'b00, num_mag};
      assign den_in  = den;
      assign quo_in  = '0;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign trial   = {rem_r[i-1], 1'b0};
      assign den_in  = den_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    // Trial subtract: remainder stays below the divisor
    assign ge = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        rem_r[i]  <= ge ? MAG_W'(trial - {1'b0, den_in}) : trial[MAG_W-1:0];
        den_r[i]  <= den_in;
        quo_r[i]  <= {quo_in[FRAC_BITS-1:0], ge};
        side_r[i] <= side_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NST-1];
  assign quo       = quo_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

`default_nettype wire

### rtl/core/fixed_point_atan2_degrees.sv
// Top level: pipelined fixed-point atan2 in whole degrees.
//
//   channel   dir   handshake               payload
//   in_ch     in    valid / ready           y_value[15:0] s, x_value[15:0] s
//   out_ch    out   valid / ready           angle_deg[8:0] s
//
// One request per cycle while out_ch.ready is high; two prep stages,
// FRAC_BITS + 1 divider stages, five polynomial/output stages. Every stage
// holds a valid bit; a stage advances when empty or when the next advances, so
// bubbles are squeezed out and the input stays open while a finished result
// waits until stages fill. Reset (rst_n, synchronous) clears the valid bits only.
`default_nettype none

`include "fixed_point_atan2_degrees_defines.svh"

module fixed_point_atan2_degrees import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch
);

  localparam int QW = FRAC_BITS + 1;          // quotient magnitude
  localparam int RW = FRAC_BITS + 2;          // signed ratio, |r| <= 1.0
  localparam int PW = 2 * RW;                 // product width
  localparam int LW = FRAC_BITS + POLY_GROW;  // polynomial sum
  localparam int AW = ANG_W + 1;              // angle before negation

  // Stage readiness, output side first
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
  logic div_in_ready, div_out_valid;
  logic [QW-1:0] div_quo;
  side_t div_side;

  logic p1_v_r, p2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, out_v_r;

  assign rdy7 = !out_v_r || out_ch.ready;
  assign rdy6 = !s6_v_r || rdy7;
  assign rdy5 = !s5_v_r || rdy6;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !p2_v_r || div_in_ready;
  assign rdy1 = !p1_v_r || rdy2;

  assign in_ch.ready = rdy1;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) p1_v_r  <= in_ch.valid;
      if (rdy2) p2_v_r  <= p1_v_r;
      if (rdy3) s3_v_r  <= div_out_valid;
      if (rdy4) s4_v_r  <= s3_v_r;
      if (rdy5) s5_v_r  <= s4_v_r;
      if (rdy6) s6_v_r  <= s5_v_r;
      if (rdy7) out_v_r <= s6_v_r;
    end
  end

  // Stage 1: |y| (|-32768| = 32768 in 17 bits) and sign flags
  logic [MAG_W-1:0]       y_ext;
  logic [MAG_W-1:0]       p1_ay_nxt;
  side_t                  p1_side_nxt;
  logic [MAG_W-1:0]       p1_ay_r;
  logic signed [IN_W-1:0] p1_x_r;
  side_t                  p1_side_r;

  always_comb begin
    y_ext              = {in_ch.y_value[IN_W-1], in_ch.y_value};
    p1_ay_nxt          = in_ch.y_value[IN_W-1] ? ~y_ext + MAG_W'(1) : y_ext;
    p1_side_nxt.y_zero = (in_ch.y_value == '0);
    p1_side_nxt.x_neg  = in_ch.x_value[IN_W-1];
    p1_side_nxt.y_neg  = in_ch.y_value[IN_W-1];
    p1_side_nxt.neg_q  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_ay_r   <= p1_ay_nxt;
      p1_x_r    <= in_ch.x_value;
      p1_side_r <= p1_side_nxt;
    end
  end

  // Stage 2: numerator / divisor per half plane, numerator magnitude
  logic [MAG_W:0]   x_w, ay_w, num_w, den_w, mag_w;
  side_t            p2_side_nxt;
  logic [IN_W-1:0]  p2_num_r;
  logic [MAG_W-1:0] p2_den_r;
  side_t            p2_side_r;

  always_comb begin
    x_w   = {{2{p1_x_r[IN_W-1]}}, p1_x_r};
    ay_w  = {1'b0, p1_ay_r};
    num_w = p1_side_r.x_neg ? x_w + ay_w : x_w - ay_w;
    den_w = p1_side_r.x_neg ? ay_w - x_w : x_w + ay_w;
    mag_w = num_w[MAG_W] ? ~num_w + (MAG_W+1)'(1) : num_w;
    p2_side_nxt       = p1_side_r;
    p2_side_nxt.neg_q = num_w[MAG_W];
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p2_num_r  <= mag_w[IN_W-1:0];
      p2_den_r  <= den_w[MAG_W-1:0];
      p2_side_r <= p2_side_nxt;
    end
  end

  // Divider: truncating quotient magnitude
  fpa_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p2_v_r),
    .in_ready  (div_in_ready),
    .num_mag   (p2_num_r),
    .den       (p2_den_r),
    .in_side   (p2_side_r),
    .out_valid (div_out_valid),
    .out_ready (rdy3),
    .quo       (div_quo),
    .out_side  (div_side)
  );

  // Stage 3: apply sign to the ratio (truncation toward zero)
  logic [RW-1:0]        q_ext;
  logic signed [RW-1:0] s3_r_r;
  side_t                s3_side_r;

  assign q_ext = {1'b0, div_quo};

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_r_r    <= $signed(div_side.neg_q ? ~q_ext + RW'(1) : q_ext);
      s3_side_r <= div_side;
    end
  end

  // Stage 4: r^2 with floor shift
  logic signed [PW-1:0] prod2;
  logic signed [RW-1:0] s4_r2_r, s4_r_r;
  side_t                s4_side_r;

  assign prod2 = PW'(s3_r_r) * PW'(s3_r_r);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_r2_r   <= RW'(prod2 >>> FRAC_BITS);
      s4_r_r    <= s3_r_r;
      s4_side_r <= s3_side_r;
    end
  end

  // Stage 5: r^3 with floor shift
  logic signed [PW-1:0] prod3;
  logic signed [RW-1:0] s5_r3_r, s5_r_r;
  side_t                s5_side_r;

  assign prod3 = PW'(s4_r2_r) * PW'(s4_r_r);

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_r3_r   <= RW'(prod3 >>> FRAC_BITS);
      s5_r_r    <= s4_r_r;
      s5_side_r <= s4_side_r;
    end
  end

  // Stage 6: polynomial -56*r + 11*r^3
  logic signed [LW-1:0] r_w, r3_w, lin_nxt;
  logic signed [LW-1:0] s6_lin_r;
  side_t                s6_side_r;

  always_comb begin
    r_w     = LW'(s5_r_r);
    r3_w    = LW'(s5_r3_r);
    lin_nxt = LW'(LIN_COEF) * r_w + LW'(CUBE_COEF) * r3_w;
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_lin_r  <= lin_nxt;
      s6_side_r <= s5_side_r;
    end
  end

  // Stage 7: base + scaled polynomial, sign, zero-y override
  logic signed [AW-1:0]    poly_deg, base_deg, ang_pos, ang_fin;
  logic signed [ANG_W-1:0] out_angle_r;

  always_comb begin
    poly_deg = AW'(s6_lin_r >>> FRAC_BITS);
    base_deg = s6_side_r.x_neg ? AW'(BASE_LEFT) : AW'(BASE_RIGHT);
    ang_pos  = base_deg + poly_deg;
    if (s6_side_r.y_zero) begin
      ang_fin = s6_side_r.x_neg ? AW'(HALF_TURN) : '0;
    end else if (s6_side_r.y_neg) begin
      ang_fin = -ang_pos;
    end else begin
      ang_fin = ang_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7) begin
      out_angle_r <= ang_fin[ANG_W-1:0];
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.angle_deg = out_angle_r;

  // Checks
  `FPA_ASSERT_IMPL(a_angle_range, out_ch.valid,
    (out_ch.angle_deg <= HALF_TURN) && (out_ch.angle_deg >= -HALF_TURN),
    "angle outside -180..180")
  `FPA_ASSERT_IMPL(a_quo_bound, div_out_valid && !div_side.y_zero,
    div_quo <= QW'(1 << FRAC_BITS), "ratio magnitude above 1.0")
  `FPA_ASSERT_IMPL(a_stall_from_output, !in_ch.ready, out_ch.valid,
    "input blocked while output empty")
  `FPA_ASSERT_NEXT(a_last_stage_moves, s6_v_r && rdy7, out_ch.valid,
    "request lost at output register")

endmodule

`default_nettype wire
